/* rtl/ranrot_word_generator_unit_defines.svh */
// Assertion helpers for the generator RTL, used by rrg_ctrl.
// They sample on clk_i and stay quiet while rst_ni is low.
`ifndef RANROT_WORD_GENERATOR_UNIT_DEFINES_SVH
`define RANROT_WORD_GENERATOR_UNIT_DEFINES_SVH

`define RRG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`define RRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/rrg_pkg.sv */
package rrg_pkg;

  localparam int unsigned LONG_LAG    = 17;
  localparam int unsigned SHORT_LAG   = 9;
  localparam int unsigned LAG         = SHORT_LAG % LONG_LAG;
  localparam int unsigned IDX_W       = $clog2(LONG_LAG);
  localparam int unsigned CNT_W       = $clog2(LONG_LAG + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LOAD_IDX_W  = 5;
  localparam int unsigned ROT_SELF    = 9;
  localparam int unsigned ROT_PARTNER = 13;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REFILL,
    S_READ
  } rrg_state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
  } rrg_mem_req_t;

  // Index of the word that feeds entry i during a refill.
  function automatic logic [IDX_W-1:0] partner_idx(input logic [IDX_W-1:0] i);
    if (i >= IDX_W'(LAG)) begin
      return i - IDX_W'(LAG);
    end else begin
      return i + IDX_W'(LONG_LAG - LAG);
    end
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] self_w,
                                            input logic [WORD_W-1:0] part_w);
    return rotl(self_w, ROT_SELF) + rotl(part_w, ROT_PARTNER);
  endfunction

endpackage

/* rtl/rrg_mem.sv */
module rrg_mem
  import rrg_pkg::*;
(
  input  logic              clk_i,
  input  rrg_mem_req_t      req_i,
  output logic [WORD_W-1:0] rdata_a_o,
  output logic [WORD_W-1:0] rdata_b_o
);

  logic [WORD_W-1:0] mem [LONG_LAG];
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;
  logic [WORD_W-1:0] wdata_q;
  logic              fwd_a_q;
  logic              fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // A read of the entry written in the same cycle returns the new word.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_a_q <= mem[req_i.raddr_a];
      rdata_b_q <= mem[req_i.raddr_b];
      wdata_q   <= req_i.wdata;
      fwd_a_q   <= req_i.we && (req_i.waddr == req_i.raddr_a);
      fwd_b_q   <= req_i.we && (req_i.waddr == req_i.raddr_b);
    end
  end

  assign rdata_a_o = fwd_a_q ? wdata_q : rdata_a_q;
  assign rdata_b_o = fwd_b_q ? wdata_q : rdata_b_q;

endmodule

/* rtl/rrg_ctrl.sv */
`include "ranrot_word_generator_unit_defines.svh"

module rrg_ctrl
  import rrg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [WORD_W-1:0]     load_word_i,
  input  logic                  out_free_i,
  output logic                  push_o,
  output rrg_mem_req_t          mem_req_o,
  input  logic [WORD_W-1:0]     rdata_a_i,
  input  logic [WORD_W-1:0]     rdata_b_i
);

  rrg_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] pos_dec;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic             stage_vld_q, stage_vld_d;
  logic             issue_done;

  assign pos_dec    = pos_q - CNT_W'(1);
  assign issue_done = (cnt_q == CNT_W'(LONG_LAG));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && (op_i == OP_DRAW)) begin
          state_d = (pos_q == '0) ? S_REFILL : S_READ;
        end
      end
      S_REFILL: begin
        if (issue_done) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    mem_req_o   = '0;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    wr_idx_d    = wr_idx_q;
    stage_vld_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == OP_LOAD) begin
            mem_req_o.we    = (load_index_i < LOAD_IDX_W'(LONG_LAG));
            mem_req_o.waddr = load_index_i[IDX_W-1:0];
            mem_req_o.wdata = load_word_i;
            pos_d           = '0;
          end else if (pos_q == '0) begin
            cnt_d = '0;
          end else begin
            mem_req_o.re      = 1'b1;
            mem_req_o.raddr_a = pos_dec[IDX_W-1:0];
            pos_d             = pos_dec;
          end
        end
      end
      S_REFILL: begin
        // Reads for entry i overlap the write-back of entry i-1.
        if (stage_vld_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = wr_idx_q;
          mem_req_o.wdata = mix(rdata_a_i, rdata_b_i);
        end
        if (!issue_done) begin
          mem_req_o.re      = 1'b1;
          mem_req_o.raddr_a = cnt_q[IDX_W-1:0];
          mem_req_o.raddr_b = partner_idx(cnt_q[IDX_W-1:0]);
          wr_idx_d          = cnt_q[IDX_W-1:0];
          stage_vld_d       = 1'b1;
          cnt_d             = cnt_q + CNT_W'(1);
        end else begin
          // The top word is read while it is being written; the memory forwards it.
          mem_req_o.re      = 1'b1;
          mem_req_o.raddr_a = IDX_W'(LONG_LAG - 1);
          pos_d             = CNT_W'(LONG_LAG - 1);
        end
      end
      S_READ: begin
        push_o = out_free_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      stage_vld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      stage_vld_q <= stage_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_idx_q <= wr_idx_d;
  end

  `RRG_ASSERT_IMPL(a_wr_in_range, mem_req_o.we, CNT_W'(mem_req_o.waddr) < CNT_W'(LONG_LAG), "write address beyond the store")
  `RRG_ASSERT_IMPL(a_rd_in_range, mem_req_o.re, (CNT_W'(mem_req_o.raddr_a) < CNT_W'(LONG_LAG)) && (CNT_W'(mem_req_o.raddr_b) < CNT_W'(LONG_LAG)), "read address beyond the store")
  `RRG_ASSERT_ALWAYS(a_pos_bound, pos_q <= CNT_W'(LONG_LAG), "read position beyond the store")
  `RRG_ASSERT_IMPL(a_stage_in_refill, stage_vld_q, state_q == S_REFILL, "refill stage busy outside a refill")

endmodule

/* rtl/ranrot_word_generator_unit.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   op_i, load_index_i, load_word_i
// out      output     out_valid_o / out_ready_i random_word_o
//
// A load word is accepted and written in IDLE. A draw from a filled buffer is accepted and
// issues one memory read, then pushes its word from S_READ. A draw on a spent buffer first
// refills the store, which writes one word per cycle through the single memory write port.
// Reset clears the read position (buffer spent); the word store is not cleared.
// A waiting result in the output register does not block acceptance of the next word;
// a draw then holds its read data until the output register frees up.
module ranrot_word_generator_unit
  import rrg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [WORD_W-1:0]     load_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WORD_W-1:0]     random_word_o
);

  rrg_mem_req_t      mem_req;
  logic [WORD_W-1:0] rdata_a;
  logic [WORD_W-1:0] rdata_b;
  logic              push;
  logic              out_free;
  logic              out_valid_q;
  logic [WORD_W-1:0] random_word_q;

  assign out_free = !out_valid_q || out_ready_i;

  rrg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .load_index_i (load_index_i),
    .load_word_i  (load_word_i),
    .out_free_i   (out_free),
    .push_o       (push),
    .mem_req_o    (mem_req),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b)
  );

  rrg_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      random_word_q <= rdata_a;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = random_word_q;

endmodule

/* dv/ranrot_word_generator_unit_checker.sv */
module ranrot_word_generator_unit_checker
  import rrg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  op_i,
  input  logic [LOAD_IDX_W-1:0] load_index_i,
  input  logic [WORD_W-1:0]     load_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [WORD_W-1:0]     random_word_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           words_owed_o
);

  logic [WORD_W-1:0] seed_words [LONG_LAG];
  int unsigned       unread_words;
  logic [WORD_W-1:0] expected_words [$];
  int unsigned       mismatch_total = 0;
  int unsigned       owed_total = 0;

  assign mismatch_count_o = mismatch_total;
  assign words_owed_o     = owed_total;

  function automatic logic [WORD_W-1:0] rotated(input logic [WORD_W-1:0] w,
                                                input int unsigned by);
    logic [2*WORD_W-1:0] twice;
    twice = {w, w} << by;
    return twice[2*WORD_W-1 -: WORD_W];
  endfunction

  // Entries are renewed in ascending order, so a partner below the current
  // index has already been renewed in this pass.
  task automatic renew_seed_words();
    int unsigned partner;
    for (int unsigned i = 0; i < LONG_LAG; i++) begin
      partner = (i + LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;
      seed_words[i] = rotated(seed_words[i], ROT_SELF) +
                      rotated(seed_words[partner], ROT_PARTNER);
    end
    unread_words = LONG_LAG;
  endtask

  task automatic predict_word(input logic op, input logic [LOAD_IDX_W-1:0] idx,
                              input logic [WORD_W-1:0] data);
    if (op == OP_LOAD) begin
      if (idx < LONG_LAG) seed_words[idx] = data;
      unread_words = 0;
    end else begin
      if (unread_words == 0) renew_seed_words();
      unread_words--;
      expected_words.push_back(seed_words[unread_words]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [WORD_W-1:0] want;
    if (!rst_ni) begin
      foreach (seed_words[i]) seed_words[i] = '0;
      unread_words = 0;
      expected_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("random_word: expected none, actual %08h", random_word_i);
          mismatch_total++;
        end else begin
          want = expected_words.pop_front();
          if (want !== random_word_i) begin
            $error("random_word: expected %08h, actual %08h", want, random_word_i);
            mismatch_total++;
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_word(op_i, load_index_i, load_word_i);
    end
    owed_total = expected_words.size();
  end

endmodule

/* dv/tb_ranrot_word_generator_unit.sv */
module tb_ranrot_word_generator_unit;
  import rrg_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  op_i = OP_DRAW;
  logic [LOAD_IDX_W-1:0] load_index_i = '0;
  logic [WORD_W-1:0]     load_word_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [WORD_W-1:0]     random_word_o;

  int unsigned mismatch_count;
  int unsigned words_owed;
  bit          idling_on = 1'b1;
  int unsigned words_sent = 0;
  int unsigned stall_left = 0;

  localparam int unsigned TOTAL_WORDS = 450;

  always #5 clk_i = ~clk_i;

  ranrot_word_generator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .load_index_i (load_index_i),
    .load_word_i  (load_word_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .random_word_o(random_word_o)
  );

  ranrot_word_generator_unit_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .load_index_i    (load_index_i),
    .load_word_i     (load_word_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .random_word_i   (random_word_o),
    .mismatch_count_o(mismatch_count),
    .words_owed_o    (words_owed)
  );

  function automatic logic [WORD_W-1:0] seed_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input logic op, input logic [LOAD_IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] data);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    load_index_i <= idx;
    load_word_i  <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic draw_words(input int unsigned count);
    repeat (count) send_word(OP_DRAW, LOAD_IDX_W'($urandom), $urandom);
  endtask

  // Output side stalls in bursts while idling is enabled.
  initial begin
    forever begin
      @(negedge clk_i);
      if (idling_on && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #3000000;
    $display("FAIL ranrot_word_generator_unit");
    $finish;
  end

  initial begin
    int unsigned pick;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every word of the store must be loaded before the first draw.
    send_word(OP_LOAD, LOAD_IDX_W'(0), '0);
    send_word(OP_LOAD, LOAD_IDX_W'(1), '1);
    send_word(OP_LOAD, LOAD_IDX_W'(2), 32'h8000_0000);
    send_word(OP_LOAD, LOAD_IDX_W'(3), 32'h0000_0001);
    send_word(OP_LOAD, LOAD_IDX_W'(4), 32'hAAAA_AAAA);
    send_word(OP_LOAD, LOAD_IDX_W'(5), 32'h5555_5555);
    for (int unsigned i = 6; i < LONG_LAG; i++) send_word(OP_LOAD, LOAD_IDX_W'(i), $urandom);
    // Indexes past the store write nothing but still spend the buffer.
    send_word(OP_LOAD, '1, $urandom);
    send_word(OP_LOAD, LOAD_IDX_W'(LONG_LAG), '1);
    draw_words(3);
    send_word(OP_LOAD, LOAD_IDX_W'(LONG_LAG - 1), 32'hDEAD_BEEF);
    draw_words(2);

    while (words_sent < TOTAL_WORDS) begin
      if (words_sent > TOTAL_WORDS - 80) idling_on = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        draw_words($urandom_range(1, 40));
      end else if (pick == 7) begin
        for (int unsigned i = 0; i < LONG_LAG; i++) begin
          send_word(OP_LOAD, LOAD_IDX_W'(i), seed_value());
        end
      end else if ($urandom_range(0, 3) == 0) begin
        send_word(OP_LOAD, LOAD_IDX_W'($urandom_range(LONG_LAG, 31)), seed_value());
      end else begin
        send_word(OP_LOAD, LOAD_IDX_W'($urandom_range(0, LONG_LAG - 1)), seed_value());
      end
    end
    in_valid_i <= 1'b0;

    wait (words_owed == 0);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && words_owed == 0) begin
      $display("PASS ranrot_word_generator_unit");
    end else begin
      $display("FAIL ranrot_word_generator_unit");
    end
    $finish;
  end

endmodule
